// File: rtl/bfsam_pkg.sv
package bfsam_pkg;

    localparam int NODES  = 16;
    localparam int NODE_W = 4;
    localparam int PTR_W  = $clog2(NODES + 1);

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TRAV = 1'b1;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [NODES-1:0]  t_row;

    // controller -> datapath
    typedef struct packed {
        logic add_edge;    // set both matrix bits of the input pair
        logic start_trav;  // clear marks, seed the FIFO with the start node
        logic load_row;    // pop the FIFO head and fetch its row
        logic step;        // take the lowest unvisited neighbor
        logic flush;       // emit the held node as the final result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fifo_nonempty;
        logic cand_any;
    } t_sts;

endpackage

// File: rtl/bfsam_ctrl.sv
module bfsam_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  bfsam_pkg::t_sts   i_sts,
    output bfsam_pkg::t_cmd   o_cmd,
    output logic              o_busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_op == bfsam_pkg::OP_TRAV) begin
                        o_cmd.start_trav = 1'b1;
                        n_state          = ST_LOAD;
                    end else begin
                        o_cmd.add_edge = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                if (i_sts.fifo_nonempty) begin
                    o_cmd.load_row = 1'b1;
                    n_state        = ST_SCAN;
                end else begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_sts.cand_any) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: rtl/bfsam_dp.sv
module bfsam_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfsam_pkg::t_cmd    i_cmd,
    input  bfsam_pkg::t_node   i_node_a,
    input  bfsam_pkg::t_node   i_node_b,
    output bfsam_pkg::t_sts    o_sts,
    output logic               o_valid,
    output bfsam_pkg::t_node   o_visit_node,
    output logic               o_last
);

    bfsam_pkg::t_row  r_adj [bfsam_pkg::NODES];
    bfsam_pkg::t_node r_fifo [bfsam_pkg::NODES];
    logic [bfsam_pkg::PTR_W-1:0] r_head;
    logic [bfsam_pkg::PTR_W-1:0] r_tail;
    bfsam_pkg::t_row  r_visited;
    bfsam_pkg::t_row  r_row;
    bfsam_pkg::t_node r_pending;
    logic             r_out_valid;
    bfsam_pkg::t_node r_out_node;
    logic             r_out_last;

    bfsam_pkg::t_row  cand;
    bfsam_pkg::t_node pick;

    assign cand = r_row & ~r_visited;

    // lowest set bit wins
    always_comb begin
        pick = '0;
        for (int i = bfsam_pkg::NODES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                pick = bfsam_pkg::t_node'(i);
            end
        end
    end

    assign o_sts.fifo_nonempty = (r_head != r_tail);
    assign o_sts.cand_any      = |cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bfsam_pkg::NODES; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_cmd.add_edge) begin
            r_adj[i_node_a][i_node_b] <= 1'b1;
            r_adj[i_node_b][i_node_a] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_trav) begin
            r_fifo[0] <= i_node_a;
        end else if (i_cmd.step) begin
            r_fifo[r_tail[bfsam_pkg::NODE_W-1:0]] <= pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_visited <= '0;
        end else begin
            if (i_cmd.start_trav) begin
                r_head    <= '0;
                r_tail    <= bfsam_pkg::PTR_W'(1);
                r_visited <= bfsam_pkg::t_row'(1) << i_node_a;
            end else begin
                if (i_cmd.load_row) begin
                    r_head <= r_head + 1'b1;
                end
                if (i_cmd.step) begin
                    r_tail    <= r_tail + 1'b1;
                    r_visited <= r_visited | (bfsam_pkg::t_row'(1) << pick);
                end
            end
        end
    end

    // hold one node back so the final one can carry the last flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row) begin
            r_row <= r_adj[r_fifo[r_head[bfsam_pkg::NODE_W-1:0]]];
        end
        if (i_cmd.start_trav) begin
            r_pending <= i_node_a;
        end else if (i_cmd.step) begin
            r_pending <= pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.step | i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_node <= r_pending;
        r_out_last <= i_cmd.flush;
    end

    assign o_valid      = r_out_valid;
    assign o_visit_node = r_out_node;
    assign o_last       = r_out_last;

endmodule

// File: rtl/bfs_adjacency_matrix.sv
// Breadth-first search over a 16-node undirected graph held as a bit matrix.
// A transaction is taken when start is high and busy is low. An edge
// transaction (op 0) sets both matrix bits and produces no result. A
// traversal transaction (op 1) emits every node reachable from node_a in
// breadth-first order, ascending index among the neighbors of one node, one
// result per o_valid strobe; the final result has o_last set. The receiver
// cannot stall: each result is on the ports for exactly one cycle.
// While a traversal runs busy is high. The controller pops the FIFO (row
// fetch), then takes one neighbor per step (priority encoder on the row)
// until the row has no neighbor left, and when the FIFO is empty it releases
// the final node; the final strobe appears in the first cycle with busy low.
// The matrix is cleared by reset.
module bfs_adjacency_matrix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_op,
    input  logic [3:0]       i_node_a,
    input  logic [3:0]       i_node_b,
    output logic             o_valid,
    output logic [3:0]       o_visit_node,
    output logic             o_last
);

    bfsam_pkg::t_cmd cmd;
    bfsam_pkg::t_sts sts;

    bfsam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bfsam_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_visit_node (o_visit_node),
        .o_last       (o_last)
    );

    // final result only after the controller has gone idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("final result while traversal still running");

    // a result without the last flag means more results follow
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final result with controller idle");

    // an accepted traversal holds busy the next cycle
    a_trav_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_op == bfsam_pkg::OP_TRAV) |=> busy)
        else $error("traversal accepted but busy not raised");

    // an edge transaction produces no result
    a_edge_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_op == bfsam_pkg::OP_EDGE) |=> !o_valid && !busy)
        else $error("edge transaction produced a result or raised busy");

endmodule
